// ----- hw/rtl/atlc_pkg.sv -----
// Shared types and constants of the adaptive traffic light controller.
// No dependencies; every other file of the block uses this package.
package atlc_pkg;

	// Road and field geometry.
	localparam int ROADS    = 4;
	localparam int ROAD_W   = 2;
	localparam int ARRIVE_W = 3;
	localparam int LIGHT_W  = 2;
	localparam int CARS_W   = 8;
	localparam int PHASE_W  = 8;

	// Defaults for the storage width parameters of the top level.
	localparam int COUNT_BITS_DEF = 8;
	localparam int WAIT_BITS_DEF  = 16;

	// Configuration port geometry and register map.
	localparam int CFG_W    = 8;
	localparam int PDATA_W  = 32;
	localparam int PADDR_W  = 4;
	localparam int REG_IDX_W = 2;

	localparam logic [REG_IDX_W-1:0] REG_CYCLE_LENGTH = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_WEIGHT_CARS  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_WEIGHT_WAIT  = 2'd2;

	localparam logic [CFG_W-1:0] CYCLE_LENGTH_RST = 8'd10;
	localparam logic [CFG_W-1:0] WEIGHT_CARS_RST  = 8'd1;
	localparam logic [CFG_W-1:0] WEIGHT_WAIT_RST  = 8'd1;

	// Light states of one road.
	typedef enum logic [LIGHT_W-1:0] {
		LT_RED   = 2'd0,
		LT_YTG   = 2'd1,
		LT_GREEN = 2'd2,
		LT_YTR   = 2'd3
	} light_t;

	// Configuration register contents handed to the datapath.
	typedef struct packed {
		logic [CFG_W-1:0] cycle_length;
		logic [CFG_W-1:0] weight_cars;
		logic [CFG_W-1:0] weight_wait;
	} cfg_t;

	// One result of a tick.
	typedef struct packed {
		logic                            departed;
		logic [ROAD_W-1:0]               departed_road;
		logic [ROADS-1:0][LIGHT_W-1:0]   light;
		logic [ROADS-1:0][CARS_W-1:0]    cars;
		logic                            arrival_dropped;
	} result_t;

endpackage

// ----- hw/rtl/atlc_tick_if.sv -----
// Input channel of the traffic light controller: one tick of arrival counts.
// Depends on atlc_pkg for the field widths.
interface atlc_tick_if;
	logic                          valid;
	logic                          ready;
	logic [atlc_pkg::ARRIVE_W-1:0] arrive_north;
	logic [atlc_pkg::ARRIVE_W-1:0] arrive_east;
	logic [atlc_pkg::ARRIVE_W-1:0] arrive_south;
	logic [atlc_pkg::ARRIVE_W-1:0] arrive_west;

	modport source (output valid, arrive_north, arrive_east, arrive_south, arrive_west,
		input ready);
	modport sink (input valid, arrive_north, arrive_east, arrive_south, arrive_west,
		output ready);
endinterface

// ----- hw/rtl/atlc_result_if.sv -----
// Output channel of the traffic light controller: one result per tick.
// Depends on atlc_pkg for the field widths.
interface atlc_result_if;
	logic                         valid;
	logic                         ready;
	logic                         departed;
	logic [atlc_pkg::ROAD_W-1:0]  departed_road;
	logic [atlc_pkg::LIGHT_W-1:0] light_north;
	logic [atlc_pkg::LIGHT_W-1:0] light_east;
	logic [atlc_pkg::LIGHT_W-1:0] light_south;
	logic [atlc_pkg::LIGHT_W-1:0] light_west;
	logic [atlc_pkg::CARS_W-1:0]  cars_north;
	logic [atlc_pkg::CARS_W-1:0]  cars_east;
	logic [atlc_pkg::CARS_W-1:0]  cars_south;
	logic [atlc_pkg::CARS_W-1:0]  cars_west;
	logic                         arrival_dropped;

	modport source (output valid, departed, departed_road, light_north, light_east,
		light_south, light_west, cars_north, cars_east, cars_south, cars_west,
		arrival_dropped, input ready);
	modport sink (input valid, departed, departed_road, light_north, light_east,
		light_south, light_west, cars_north, cars_east, cars_south, cars_west,
		arrival_dropped, output ready);
endinterface

// ----- hw/rtl/atlc_cfg.sv -----
// APB-style configuration registers: cycle length and the two priority weights.
// Depends on atlc_pkg for the register map, reset values and cfg_t.
module atlc_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [atlc_pkg::PADDR_W-1:0]  paddr,
	input  logic [atlc_pkg::PDATA_W-1:0]  pwdata,
	output logic [atlc_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output atlc_pkg::cfg_t                cfg
);

	logic                              wr_en;
	logic [atlc_pkg::REG_IDX_W-1:0]    reg_idx;
	logic [atlc_pkg::CFG_W-1:0]        cycle_length_q;
	logic [atlc_pkg::CFG_W-1:0]        weight_cars_q;
	logic [atlc_pkg::CFG_W-1:0]        weight_wait_q;

	// Registers sit on word addresses; the write lands in the access phase.
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[atlc_pkg::PADDR_W-1:2];

	// Register file with reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_length_q <= atlc_pkg::CYCLE_LENGTH_RST;
			weight_cars_q  <= atlc_pkg::WEIGHT_CARS_RST;
			weight_wait_q  <= atlc_pkg::WEIGHT_WAIT_RST;
		end else if (wr_en) begin
			case (reg_idx)
				atlc_pkg::REG_CYCLE_LENGTH: cycle_length_q <= pwdata[atlc_pkg::CFG_W-1:0];
				atlc_pkg::REG_WEIGHT_CARS:  weight_cars_q  <= pwdata[atlc_pkg::CFG_W-1:0];
				atlc_pkg::REG_WEIGHT_WAIT:  weight_wait_q  <= pwdata[atlc_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back, zero-extended to the bus width.
	always_comb begin
		case (reg_idx)
			atlc_pkg::REG_CYCLE_LENGTH: prdata = atlc_pkg::PDATA_W'(cycle_length_q);
			atlc_pkg::REG_WEIGHT_CARS:  prdata = atlc_pkg::PDATA_W'(weight_cars_q);
			atlc_pkg::REG_WEIGHT_WAIT:  prdata = atlc_pkg::PDATA_W'(weight_wait_q);
			default:                    prdata = '0;
		endcase
	end

	assign cfg.cycle_length = cycle_length_q;
	assign cfg.weight_cars  = weight_cars_q;
	assign cfg.weight_wait  = weight_wait_q;

endmodule

// ----- hw/rtl/atlc_rank.sv -----
// Road priority and ranking: two products per road and a four-way rank.
// Depends on atlc_pkg for road geometry and weight width.
module atlc_rank #(
	parameter int COUNT_BITS = atlc_pkg::COUNT_BITS_DEF,
	parameter int WAIT_BITS  = atlc_pkg::WAIT_BITS_DEF
) (
	input  logic [atlc_pkg::ROADS-1:0][COUNT_BITS-1:0]      count,
	input  logic [atlc_pkg::ROADS-1:0][WAIT_BITS-1:0]       wait_cnt,
	input  logic [atlc_pkg::ROADS-1:0]                      red,
	input  logic [atlc_pkg::CFG_W-1:0]                      weight_cars,
	input  logic [atlc_pkg::CFG_W-1:0]                      weight_wait,
	output logic [atlc_pkg::ROADS-1:0][atlc_pkg::ROAD_W-1:0] rank_order
);

	localparam int WIDE_BITS = (COUNT_BITS > WAIT_BITS) ? COUNT_BITS : WAIT_BITS;
	localparam int PRIO_W    = WIDE_BITS + atlc_pkg::CFG_W + 1;
	localparam int POS_W     = atlc_pkg::ROAD_W + 1;
	localparam int RW        = atlc_pkg::ROAD_W;

	logic [PRIO_W-1:0] prio [atlc_pkg::ROADS];

	// Priority: cars times weight, plus wait times weight while red; zero when empty.
	always_comb begin
		logic [COUNT_BITS+atlc_pkg::CFG_W-1:0] car_term;
		logic [WAIT_BITS+atlc_pkg::CFG_W-1:0]  wait_term;
		for (int r = 0; r < atlc_pkg::ROADS; r++) begin
			car_term  = count[r] * weight_cars;
			wait_term = wait_cnt[r] * weight_wait;
			prio[r]   = '0;
			if (count[r] != '0) begin
				prio[r] = PRIO_W'(car_term);
				if (red[r]) begin
					prio[r] = PRIO_W'(car_term) + PRIO_W'(wait_term);
				end
			end
		end
	end

	// Each road's place is the number of roads ahead of it; ties favor the lower index.
	always_comb begin
		logic [POS_W-1:0] pos;
		rank_order = '0;
		for (int i = 0; i < atlc_pkg::ROADS; i++) begin
			pos = '0;
			for (int j = 0; j < atlc_pkg::ROADS; j++) begin
				if (prio[j] > prio[i] || (prio[j] == prio[i] && j < i)) begin
					pos = pos + POS_W'(1);
				end
			end
			rank_order[pos[RW-1:0]] = RW'(i);
		end
	end

endmodule

// ----- hw/rtl/atlc_tick_unit.sv -----
// Intersection state and the per-tick update: departure, arrivals, lights, waits, phase.
// Depends on atlc_pkg and instantiates atlc_rank.
module atlc_tick_unit #(
	parameter int COUNT_BITS = atlc_pkg::COUNT_BITS_DEF,
	parameter int WAIT_BITS  = atlc_pkg::WAIT_BITS_DEF
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              step,
	input  logic [atlc_pkg::ROADS-1:0][atlc_pkg::ARRIVE_W-1:0] arrive,
	input  atlc_pkg::cfg_t                                    cfg,
	output atlc_pkg::result_t                                 result
);

	localparam int ROADS = atlc_pkg::ROADS;
	localparam int RW    = atlc_pkg::ROAD_W;
	localparam int PW    = atlc_pkg::PHASE_W;
	localparam int CW    = atlc_pkg::CARS_W;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [WAIT_BITS-1:0]  WAIT_MAX  = '1;
	localparam logic [PW-1:0] PH_RANK   = 8'd0;
	localparam logic [PW-1:0] PH_GREEN1 = 8'd1;
	localparam logic [PW-1:0] PH_GREEN2 = 8'd2;

	// Intersection state.
	atlc_pkg::light_t [ROADS-1:0]        light_q;
	logic [ROADS-1:0][COUNT_BITS-1:0]    count_q;
	logic [ROADS-1:0][WAIT_BITS-1:0]     wait_q;
	logic [ROADS-1:0][RW-1:0]            rank_q;
	logic [PW-1:0]                       phase_q;

	// Next values.
	atlc_pkg::light_t [ROADS-1:0]        light_n;
	logic [ROADS-1:0][COUNT_BITS-1:0]    count_n;
	logic [ROADS-1:0][WAIT_BITS-1:0]     wait_n;
	logic [ROADS-1:0][RW-1:0]            rank_n;
	logic [ROADS-1:0][RW-1:0]            rank_new;
	logic [PW-1:0]                       phase_n;
	logic [PW:0]                         phase_inc;
	logic [ROADS-1:0]                    red;
	logic                                departed;
	logic [RW-1:0]                       dep_road;
	logic                                dropped;
	logic                                ph_green;
	logic                                ph_red;

	// One car leaves from the first green road that holds cars.
	always_comb begin
		departed = 1'b0;
		dep_road = '0;
		for (int r = 0; r < ROADS; r++) begin
			if (!departed && light_q[r] == atlc_pkg::LT_GREEN && count_q[r] != '0) begin
				departed = 1'b1;
				dep_road = RW'(r);
			end
		end
	end

	// Departure, then saturating arrivals.
	always_comb begin
		logic [COUNT_BITS-1:0] after_dep;
		logic [COUNT_BITS-1:0] room;
		logic [COUNT_BITS-1:0] add;
		dropped = 1'b0;
		for (int r = 0; r < ROADS; r++) begin
			after_dep = count_q[r];
			if (departed && dep_road == RW'(r)) begin
				after_dep = count_q[r] - COUNT_BITS'(1);
			end
			room = COUNT_MAX - after_dep;
			add  = COUNT_BITS'(arrive[r]);
			if (add > room) begin
				dropped = 1'b1;
				add     = room;
			end
			count_n[r] = after_dep + add;
		end
	end

	// Priorities use the lights and waits from before this tick's light changes.
	always_comb begin
		for (int r = 0; r < ROADS; r++) begin
			red[r] = (light_q[r] == atlc_pkg::LT_RED);
		end
	end

	atlc_rank #(
		.COUNT_BITS (COUNT_BITS),
		.WAIT_BITS  (WAIT_BITS)
	) u_rank (
		.count       (count_n),
		.wait_cnt    (wait_q),
		.red         (red),
		.weight_cars (cfg.weight_cars),
		.weight_wait (cfg.weight_wait),
		.rank_order  (rank_new)
	);

	assign rank_n   = (phase_q == PH_RANK) ? rank_new : rank_q;
	assign ph_green = (phase_q == PH_GREEN1) || (phase_q == PH_GREEN2);
	assign ph_red   = (phase_q == PH_RANK) || (phase_q == PH_GREEN1);

	// By phase, top road steps to green, others to red; a change restarts the wait.
	always_comb begin
		logic go_green;
		logic go_red;
		logic clr;
		logic [WAIT_BITS-1:0] w;
		for (int r = 0; r < ROADS; r++) begin
			go_green   = ph_green && (rank_n[0] == RW'(r));
			go_red     = ph_red && (rank_n[0] != RW'(r));
			light_n[r] = light_q[r];
			clr        = 1'b0;
			case (light_q[r])
				atlc_pkg::LT_RED: begin
					if (go_green) begin
						light_n[r] = atlc_pkg::LT_YTG;
						clr        = 1'b1;
					end
				end
				atlc_pkg::LT_YTG: begin
					if (go_green) begin
						light_n[r] = atlc_pkg::LT_GREEN;
						clr        = 1'b1;
					end
				end
				atlc_pkg::LT_GREEN: begin
					if (go_red) begin
						light_n[r] = atlc_pkg::LT_YTR;
						clr        = 1'b1;
					end
				end
				atlc_pkg::LT_YTR: begin
					if (go_red) begin
						light_n[r] = atlc_pkg::LT_RED;
						clr        = 1'b1;
					end
				end
				default: ;
			endcase
			w = clr ? '0 : wait_q[r];
			if (count_n[r] != '0 && w != WAIT_MAX) begin
				w = w + WAIT_BITS'(1);
			end
			wait_n[r] = w;
		end
	end

	// Phase advances and wraps at the cycle length.
	assign phase_inc = {1'b0, phase_q} + (PW+1)'(1);
	assign phase_n   = (phase_inc >= {1'b0, cfg.cycle_length}) ? '0 : phase_inc[PW-1:0];

	// State update, one tick per step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROADS; r++) begin
				light_q[r] <= atlc_pkg::LT_RED;
				count_q[r] <= '0;
				wait_q[r]  <= '0;
				rank_q[r]  <= RW'(r);
			end
			phase_q <= '0;
		end else if (step) begin
			light_q <= light_n;
			count_q <= count_n;
			wait_q  <= wait_n;
			rank_q  <= rank_n;
			phase_q <= phase_n;
		end
	end

	// Result of this tick.
	always_comb begin
		result.departed        = departed;
		result.departed_road   = dep_road;
		result.arrival_dropped = dropped;
		for (int r = 0; r < ROADS; r++) begin
			result.light[r] = light_n[r];
			result.cars[r]  = CW'(count_n[r]);
		end
	end

endmodule

// ----- hw/rtl/adaptive_traffic_light_controller_core.sv -----
// Top level of the adaptive four-way traffic light controller.
// Depends on atlc_pkg, atlc_tick_if, atlc_result_if, atlc_cfg and atlc_tick_unit.
//
// Each tick transaction on tick_in carries the arrivals of the four roads and
// produces exactly one result transaction on result_out. The block takes one
// tick per clock cycle unless the output stalls: a tick is captured in the
// input register, and the clock edge at which it advances runs the whole tick
// update (departure, arrivals, the priority products and the four-road rank,
// light steps, waits and phase) in one pass and loads its result into the
// output register, from which result_out offers it. The input stalls only when
// both registers hold a transaction and result_out.ready is low. Configuration
// registers (cycle_length at 0x0, weight_cars at 0x4, weight_wait at 0x8) are
// written over the APB port; the user writes them only while no tick is in
// flight, and the block itself does not enforce this.
module adaptive_traffic_light_controller_core #(
	parameter int COUNT_BITS = atlc_pkg::COUNT_BITS_DEF,
	parameter int WAIT_BITS  = atlc_pkg::WAIT_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	atlc_tick_if.sink                    tick_in,
	atlc_result_if.source                result_out,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [atlc_pkg::PADDR_W-1:0] paddr,
	input  logic [atlc_pkg::PDATA_W-1:0] pwdata,
	output logic [atlc_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);

	localparam int ROADS = atlc_pkg::ROADS;

	atlc_pkg::cfg_t                                  cfg;
	atlc_pkg::result_t                               result_n;
	atlc_pkg::result_t                               result_q;
	logic [ROADS-1:0][atlc_pkg::ARRIVE_W-1:0]        arrive_s1;
	logic                                            valid_s1;
	logic                                            out_valid_q;
	logic                                            advance;
	logic                                            accept;

	atlc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The captured tick moves on when the output register is free or being emptied.
	assign advance       = valid_s1 & (~out_valid_q | result_out.ready);
	assign tick_in.ready = ~valid_s1 | advance;
	assign accept        = tick_in.valid & tick_in.ready;

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			arrive_s1 <= {tick_in.arrive_west, tick_in.arrive_south,
				tick_in.arrive_east, tick_in.arrive_north};
		end
	end

	atlc_tick_unit #(
		.COUNT_BITS (COUNT_BITS),
		.WAIT_BITS  (WAIT_BITS)
	) u_tick (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.arrive (arrive_s1),
		.cfg    (cfg),
		.result (result_n)
	);

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_n;
		end
	end

	assign result_out.valid           = out_valid_q;
	assign result_out.departed        = result_q.departed;
	assign result_out.departed_road   = result_q.departed_road;
	assign result_out.light_north     = result_q.light[0];
	assign result_out.light_east      = result_q.light[1];
	assign result_out.light_south     = result_q.light[2];
	assign result_out.light_west      = result_q.light[3];
	assign result_out.cars_north      = result_q.cars[0];
	assign result_out.cars_east       = result_q.cars[1];
	assign result_out.cars_south      = result_q.cars[2];
	assign result_out.cars_west       = result_q.cars[3];
	assign result_out.arrival_dropped = result_q.arrival_dropped;

endmodule
